// File: rtl/kfsr_pkg.sv
package kfsr_pkg;

    localparam int DEPTH        = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int KEY_W        = 64;
    localparam int ID_W         = 31;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int IDX_W        = $clog2(DEPTH);

    localparam int S_FIELDS_W = KEY_W + PAYLOAD_BITS;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = ID_W + PAYLOAD_BITS + CNT_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_FIND   = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic [ID_W-1:0]         id;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    // per-cell control from the queue controller
    typedef struct packed {
        logic valid;      // cell holds a live entry
        logic cmp_en;     // key search in progress
        logic take;       // selected entry leaves; cells at or after it shift down
        logic load_push;  // this cell is the tail slot for a push
    } kfsr_ctrl_t;

endpackage

// File: rtl/keyed_fifo_with_search_remove_top.sv
// Channel  Dir  tdata (low bit up)                       tuser
// s_       in   key, payload_in                          opcode
// m_       out  entry_id, payload_out, entry_count,      status
//               is_empty, zero fill
//
// One word per cycle: the key compare, oldest-match chain and shift all
// happen in the cell row in the cycle the word is accepted; the result
// appears in the output register on the next cycle.
// A stalled result holds the output register; a new word is taken when it
// is empty or being drained in the same cycle.
// Synchronous active-low reset empties the queue and sets the next id to 0.
module keyed_fifo_with_search_remove_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [kfsr_pkg::ID_W-1:0]       cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kfsr_pkg::S_TDATA_W-1:0]  s_tdata,   // key, payload_in
    input  logic [1:0]                      s_tuser,   // opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kfsr_pkg::M_TDATA_W-1:0]  m_tdata,   // entry_id, payload_out,
                                                       // entry_count, is_empty
    output logic [1:0]                      m_tuser    // status
);
    import kfsr_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [ID_W-1:0]  next_id_reg, next_id_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    status_t          m_status_reg, m_status_next;

    logic       accept;
    op_t        op;
    logic [KEY_W-1:0] in_key;
    entry_t     push_entry;
    entry_t     cell_q [DEPTH];
    kfsr_ctrl_t cell_ctrl [DEPTH];
    logic [DEPTH:0] hit;
    logic       found;
    logic       is_full;
    logic       take;
    logic       push_ok;
    entry_t     sel_entry;
    status_t    status;
    logic [ID_W-1:0] res_id;
    logic [PAYLOAD_BITS-1:0] res_payload;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);
    assign in_key   = s_tdata[KEY_W-1:0];
    assign is_full  = (count_reg == CNT_W'(DEPTH));

    assign push_entry.key     = in_key;
    assign push_entry.id      = next_id_reg;
    assign push_entry.payload = s_tdata[KEY_W +: PAYLOAD_BITS];

    // a pop selects the head cell directly; find/remove go by key
    assign hit[0]  = (op == OP_POP) && (count_reg != '0);
    assign found   = hit[DEPTH];
    assign take    = accept && found && ((op == OP_POP) || (op == OP_REMOVE));
    assign push_ok = accept && (op == OP_PUSH) && !is_full;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign cell_ctrl[i].valid     = (CNT_W'(i) < count_reg);
        assign cell_ctrl[i].cmp_en    = (op == OP_FIND) || (op == OP_REMOVE);
        assign cell_ctrl[i].take      = take;
        assign cell_ctrl[i].load_push = push_ok && (count_reg == CNT_W'(i));

        kfsr_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl[i]),
            .srch_key   (in_key),
            .hit_in     (hit[i]),
            .nxt_entry  (cell_q[(i + 1 < DEPTH) ? i + 1 : i]),
            .push_entry (push_entry),
            .entry      (cell_q[i]),
            .hit_out    (hit[i+1])
        );
    end

    // one-hot select of the oldest hit; the head cell also covers a pop
    always_comb begin
        sel_entry = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (hit[i+1] && ((i == 0) || !hit[i])) begin
                sel_entry = sel_entry | cell_q[i];
            end
        end
    end

    always_comb begin
        status       = ST_OK;
        res_id       = '0;
        res_payload  = '0;
        count_next   = count_reg;
        next_id_next = next_id_reg;
        case (op)
            OP_PUSH: begin
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    res_id = next_id_reg;
                end
            end
            OP_POP: begin
                if (!found) begin
                    status = ST_EMPTY;
                end
            end
            OP_FIND, OP_REMOVE: begin
                if (!found) begin
                    status = ST_NOT_FOUND;
                end
            end
            default: status = ST_OK;
        endcase
        if (found) begin
            res_id      = sel_entry.id;
            res_payload = sel_entry.payload;
        end
        if (push_ok) begin
            count_next   = count_reg + CNT_W'(1);
            next_id_next = next_id_reg + ID_W'(1);
        end else if (take) begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cfg_wr_en) begin
            next_id_next = cfg_wr_data;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_status_next = m_status_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_status_next = status;
            m_tdata_next  = M_TDATA_W'({(count_next == '0), count_next,
                                        res_payload, res_id});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            next_id_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            next_id_reg  <= next_id_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg  <= m_tdata_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_status_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (op == OP_PUSH) && is_full) |=>
            (m_tvalid && (m_tuser == ST_FULL) && (count_reg == CNT_W'(DEPTH))))
        else $error("push into full queue not dropped");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (op == OP_POP) && (count_reg != '0)) |=>
            (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop of non-empty queue did not lower count");

endmodule

// File: rtl/kfsr_cell.sv
module kfsr_cell (
    input  logic                  aclk,
    input  kfsr_pkg::kfsr_ctrl_t  ctrl,
    input  logic [kfsr_pkg::KEY_W-1:0] srch_key,
    input  logic                  hit_in,
    input  kfsr_pkg::entry_t      nxt_entry,
    input  kfsr_pkg::entry_t      push_entry,
    output kfsr_pkg::entry_t      entry,
    output logic                  hit_out
);
    import kfsr_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   self_hit;

    assign self_hit = ctrl.valid && ctrl.cmp_en && (entry_reg.key == srch_key);
    // hit_out: selected entry is this cell or an older one
    assign hit_out  = hit_in || self_hit;
    assign entry    = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.take && hit_out) begin
            entry_next = nxt_entry;
        end else if (ctrl.load_push) begin
            entry_next = push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule
